FILE: rtl/oid_pkg.sv
// oid_pkg: shared types and constants for the object identifier decoder
// depends on nothing; imported by oid_front, oid_queue, oid_back, the top level and oid_arc_checker
`timescale 1ns / 1ps

package oid_pkg;

  // accumulator width and output arc width
  localparam int ARC_BITS     = 32;
  localparam int ARC_OUT_BITS = 32;

  // octet layout
  localparam int GROUP_BITS = 7;

  // first subidentifier split points
  localparam int FIRST_SPLIT_MAX = 79;
  localparam int FIRST_SPLIT_TOP = 80;
  localparam int FIRST_DIVISOR   = 40;

  // task queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  // one queued task: one arc, or the two arcs of a first subidentifier
  typedef struct packed {
    logic                    two_arcs;
    logic [ARC_OUT_BITS-1:0] arc0;
    logic [ARC_OUT_BITS-1:0] arc1;
    logic                    last;
    logic [1:0]              status;
  } oid_task_t;

  // push side of the task queue
  typedef struct packed {
    logic      valid;
    oid_task_t data;
  } oid_push_t;

  // pop side of the task queue
  typedef struct packed {
    logic      valid;
    oid_task_t data;
  } oid_head_t;

endpackage

FILE: rtl/oid_in_if.sv
// oid_in_if: input channel carrying one content octet per request
// depends on nothing
`timescale 1ns / 1ps

interface oid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] content_byte;
  logic       end_of_content;

  modport source (output valid, output content_byte, output end_of_content, input ready);
  modport sink (input valid, input content_byte, input end_of_content, output ready);
endinterface

FILE: rtl/oid_out_if.sv
// oid_out_if: output channel carrying one decoded arc per request
// depends on nothing
`timescale 1ns / 1ps

interface oid_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] arc_value;
  logic        last_arc;
  logic [1:0]  status;

  modport source (output valid, output arc_value, output last_arc, output status, input ready);
  modport sink (input valid, input arc_value, input last_arc, input status, output ready);
endinterface

FILE: rtl/oid_front.sv
// oid_front: accepts octets, accumulates base-128 groups, classifies arcs
// depends on oid_pkg and oid_in_if; pushes tasks into oid_queue
`timescale 1ns / 1ps

module oid_front (
  input  logic              clk,
  input  logic              rst,
  oid_in_if.sink            octets,
  input  logic              queue_full,
  output oid_pkg::oid_push_t push
);
  import oid_pkg::*;

  logic [ARC_BITS-1:0] acc;
  logic                first_pending;
  logic                overflow_seen;

  logic [ARC_BITS-1:0] acc_next;
  logic                ovf_next;
  logic                more;
  logic                accept;
  logic                ends_sub;
  logic [ARC_OUT_BITS-1:0] acc_out;
  oid_task_t           task_d;

  assign octets.ready = !queue_full;
  assign accept       = octets.valid && octets.ready;
  assign more         = octets.content_byte[GROUP_BITS];
  assign ends_sub     = !more;

  // shift in the next group, saturating once the top group bits are used
  always_comb begin
    ovf_next = overflow_seen || (|acc[ARC_BITS-1 -: GROUP_BITS]);
    if (ovf_next) begin
      acc_next = '1;
    end else begin
      acc_next = {acc[ARC_BITS-GROUP_BITS-1:0], octets.content_byte[GROUP_BITS-1:0]};
    end
    acc_out = ARC_OUT_BITS'(acc_next);
  end

  // build the task for this octet
  always_comb begin
    task_d.two_arcs = 1'b0;
    task_d.arc0     = acc_out;
    task_d.arc1     = '0;
    task_d.last     = octets.end_of_content;
    task_d.status   = ovf_next ? ST_OVERFLOW : ST_OK;
    if (more) begin
      task_d.status = ST_TRUNC;
    end else if (first_pending) begin
      task_d.two_arcs = 1'b1;
      if (ovf_next) begin
        task_d.arc0 = ARC_OUT_BITS'(2);
        task_d.arc1 = acc_out;
      end else if (acc_next > ARC_BITS'(FIRST_SPLIT_MAX)) begin
        task_d.arc0 = ARC_OUT_BITS'(2);
        task_d.arc1 = ARC_OUT_BITS'(acc_next - ARC_BITS'(FIRST_SPLIT_TOP));
      end else if (acc_next >= ARC_BITS'(FIRST_DIVISOR)) begin
        task_d.arc0 = ARC_OUT_BITS'(1);
        task_d.arc1 = ARC_OUT_BITS'(acc_next - ARC_BITS'(FIRST_DIVISOR));
      end else begin
        task_d.arc0 = '0;
        task_d.arc1 = acc_out;
      end
    end
  end

  // a task goes out when a subidentifier ends or the content is cut short
  always_comb begin
    push.valid = accept && (ends_sub || octets.end_of_content);
    push.data  = task_d;
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      first_pending <= 1'b1;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (more && !octets.end_of_content) begin
        acc           <= acc_next;
        overflow_seen <= ovf_next;
      end else begin
        acc           <= '0;
        overflow_seen <= 1'b0;
        if (octets.end_of_content) begin
          first_pending <= 1'b1;
        end else begin
          first_pending <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/oid_queue.sv
// oid_queue: short task queue between the front and back parts
// depends on oid_pkg
`timescale 1ns / 1ps

module oid_queue (
  input  logic               clk,
  input  logic               rst,
  input  oid_pkg::oid_push_t push,
  input  logic               pop,
  output logic               full,
  output oid_pkg::oid_head_t head
);
  import oid_pkg::*;

  oid_task_t              slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.data  = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/oid_back.sv
// oid_back: drains tasks and presents one arc per request on the output
// depends on oid_pkg and oid_out_if; pops tasks from oid_queue
`timescale 1ns / 1ps

module oid_back (
  input  logic               clk,
  input  logic               rst,
  input  oid_pkg::oid_head_t head,
  output logic               pop,
  oid_out_if.source          arcs
);
  import oid_pkg::*;

  logic                    out_valid;
  logic [ARC_OUT_BITS-1:0] arc_value;
  logic                    last_arc;
  logic [1:0]              status;

  logic                    hold_valid;
  logic [ARC_OUT_BITS-1:0] hold_arc;
  logic                    hold_last;
  logic [1:0]              hold_status;

  logic                    load;

  assign arcs.valid     = out_valid;
  assign arcs.arc_value = arc_value;
  assign arcs.last_arc  = last_arc;
  assign arcs.status    = status;

  assign load = !out_valid || arcs.ready;
  assign pop  = load && !hold_valid && head.valid;

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (load) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        out_valid  <= head.valid;
        hold_valid <= head.valid && head.data.two_arcs;
      end
    end
  end

  // output and second-arc payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_valid) begin
        arc_value <= hold_arc;
        last_arc  <= hold_last;
        status    <= hold_status;
      end else begin
        arc_value   <= head.data.arc0;
        last_arc    <= head.data.two_arcs ? 1'b0 : head.data.last;
        status      <= head.data.status;
        hold_arc    <= head.data.arc1;
        hold_last   <= head.data.last;
        hold_status <= head.data.status;
      end
    end
  end

endmodule

FILE: rtl/oid_subidentifier_decoder_unit.sv
// oid_subidentifier_decoder_unit: top level of the object identifier decoder
// depends on oid_pkg, oid_in_if, oid_out_if, oid_front, oid_queue, oid_back
`timescale 1ns / 1ps

// Decodes BER/DER object identifier content octets, one octet per request on
// octets, into arcs, one arc per request on arcs. An octet is taken every
// cycle while the four-entry task queue has room; an arc leaves every cycle
// the sink is ready and an arc waits. A subidentifier yields one arc, except
// the first of an identifier, which yields two in turn, so the output port
// sets the sustained rate. An octet that ends a subidentifier is written to
// the queue on the edge that accepts it; its first arc then goes from the
// queue head into the output register. Arcs above 32 bits saturate with
// status overflow; content that ends mid-subidentifier gives one arc with
// status truncated and last_arc set.

module oid_subidentifier_decoder_unit (
  input  logic      clk,
  input  logic      rst,
  oid_in_if.sink    octets,
  oid_out_if.source arcs
);
  import oid_pkg::*;

  oid_push_t push;
  oid_head_t head;
  logic      queue_full;
  logic      pop;

  // accumulate and classify
  oid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .octets     (octets),
    .queue_full (queue_full),
    .push       (push)
  );

  // decouple front and back
  oid_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  // emit arcs
  oid_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .arcs (arcs)
  );

endmodule

FILE: bench/oid_arc_checker.sv
// oid_arc_checker: watches the octet and arc channels of the oid decoder,
// predicts the arcs of every accepted octet and compares them in order
// depends on oid_pkg, oid_in_if, oid_out_if
`timescale 1ns / 1ps

module oid_arc_checker (
  input  logic        clk,
  input  logic        rst,
  oid_in_if           octets,
  oid_out_if          arcs,
  output int unsigned fail_count,
  output int unsigned arcs_pending
);

  import oid_pkg::*;

  localparam logic [ARC_BITS-1:0] ARC_MAX        = '1;
  localparam logic [ARC_BITS-1:0] FIRST_HIGH_ARC = 2;

  typedef struct packed {
    logic [ARC_OUT_BITS-1:0] arc_value;
    logic                    last_arc;
    logic [1:0]              status;
  } arc_t;

  arc_t                arcs_due[$];
  logic [ARC_BITS-1:0] arc_acc;
  logic                first_due;
  logic                acc_saturated;
  int unsigned         mismatches;

  function automatic void expect_arc(input logic [ARC_BITS-1:0] value, input logic last,
                                     input logic [1:0] status);
    arc_t a;
    a.arc_value = value[ARC_OUT_BITS-1:0];
    a.last_arc  = last;
    a.status    = status;
    arcs_due.push_back(a);
  endfunction

  // fold one octet into the running subidentifier and queue the arcs it ends
  function automatic void decode_octet(input logic [7:0] octet, input logic eoc);
    logic [ARC_BITS-1:0] acc;
    logic [1:0]          status;
    if (acc_saturated || arc_acc > (ARC_MAX >> GROUP_BITS)) begin
      acc_saturated = 1'b1;
      acc = ARC_MAX;
    end else begin
      acc = (arc_acc << GROUP_BITS) | ARC_BITS'(octet[6:0]);
    end
    arc_acc = acc;

    // more groups follow: nothing out unless the content stops here
    if (octet[7]) begin
      if (eoc) begin
        expect_arc(acc, 1'b1, ST_TRUNC);
        arc_acc       = '0;
        first_due     = 1'b1;
        acc_saturated = 1'b0;
      end
      return;
    end

    status = acc_saturated ? ST_OVERFLOW : ST_OK;
    if (first_due) begin
      // first subidentifier splits into two arcs
      if (acc_saturated) begin
        expect_arc(FIRST_HIGH_ARC, 1'b0, status);
        expect_arc(ARC_MAX, eoc, status);
      end else if (acc > FIRST_SPLIT_MAX) begin
        expect_arc(FIRST_HIGH_ARC, 1'b0, status);
        expect_arc(acc - FIRST_SPLIT_TOP, eoc, status);
      end else begin
        expect_arc(acc / FIRST_DIVISOR, 1'b0, status);
        expect_arc(acc % FIRST_DIVISOR, eoc, status);
      end
      first_due = 1'b0;
    end else begin
      expect_arc(acc, eoc, status);
    end

    arc_acc       = '0;
    acc_saturated = 1'b0;
    if (eoc) first_due = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    arc_t seen;
    arc_t due;
    if (rst) begin
      arcs_due.delete();
      arc_acc       = '0;
      first_due     = 1'b1;
      acc_saturated = 1'b0;
      mismatches    = 0;
    end else begin
      // compare each arc request with the oldest prediction
      if (arcs.valid && arcs.ready) begin
        seen.arc_value = arcs.arc_value;
        seen.last_arc  = arcs.last_arc;
        seen.status    = arcs.status;
        if (arcs_due.size() == 0) begin
          $display("%0t: unexpected arc, expected none, got arc %h last %b status %0d",
                   $time, seen.arc_value, seen.last_arc, seen.status);
          mismatches++;
        end else begin
          due = arcs_due.pop_front();
          if (seen.arc_value !== due.arc_value) begin
            $display("%0t: arc_value mismatch, expected %h, got %h",
                     $time, due.arc_value, seen.arc_value);
            mismatches++;
          end
          if (seen.last_arc !== due.last_arc) begin
            $display("%0t: last_arc mismatch, expected %b, got %b",
                     $time, due.last_arc, seen.last_arc);
            mismatches++;
          end
          if (seen.status !== due.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, due.status, seen.status);
            mismatches++;
          end
        end
      end
      // predict from each accepted octet request
      if (octets.valid && octets.ready) decode_octet(octets.content_byte, octets.end_of_content);
    end
    arcs_pending <= arcs_due.size();
    fail_count   <= mismatches;
  end

endmodule

FILE: bench/oid_subidentifier_decoder_unit_test.sv
// oid_subidentifier_decoder_unit_test: drives octet requests into the oid
// decoder and stalls its arc output; oid_arc_checker does the checking
// depends on oid_pkg, oid_in_if, oid_out_if, oid_arc_checker and the rtl
`timescale 1ns / 1ps

module oid_subidentifier_decoder_unit_test;

  localparam int unsigned ITEM_TARGET = 1000;
  localparam int unsigned HOLD_AFTER  = 400;
  localparam int unsigned LONG_HOLD   = 120;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        hold_request;
  bit          steady;
  int unsigned burst_left;
  int unsigned octets_sent;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned arcs_pending;

  oid_in_if  octets();
  oid_out_if arcs();

  oid_subidentifier_decoder_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .octets (octets),
    .arcs   (arcs)
  );

  oid_arc_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .octets       (octets),
    .arcs         (arcs),
    .fail_count   (fail_count),
    .arcs_pending (arcs_pending)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("oid_subidentifier_decoder_unit_test failed");
    $finish;
  end

  // arc receiver: stall patterns by segment, plus one long hold on request
  initial begin : receiver
    int unsigned seg_left;
    int unsigned tick;
    rx_mode_t    mode;
    bit          served;
    seg_left = 0;
    tick     = 0;
    mode     = RX_OPEN;
    served   = 1'b0;
    forever begin
      if (hold_request && !served) begin
        arcs.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        served = 1'b1;
      end else begin
        if (!hold_request) served = 1'b0;
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        tick++;
        case (mode)
          RX_OPEN:   arcs.ready <= 1'b1;
          RX_COIN:   arcs.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: arcs.ready <= ($urandom_range(0, 3) == 0);
          default:   arcs.ready <= (tick % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // one octet request, with bursts and gaps unless steady
  task automatic send_octet(input logic [7:0] octet, input logic eoc);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        octets.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    octets.valid          <= 1'b1;
    octets.content_byte   <= octet;
    octets.end_of_content <= eoc;
    do @(posedge clk); while (!octets.ready);
    octets_sent++;
  endtask

  // base-128 encoding of one subidentifier with optional leading 0x80 groups
  task automatic send_subid(input logic [63:0] value, input int unsigned pad, input bit eoc);
    logic [6:0]  groups[$];
    logic [63:0] rest;
    int          i;
    rest = value;
    do begin
      groups.push_front(rest[6:0]);
      rest = rest >> 7;
    end while (rest != 0);
    repeat (pad) groups.push_front(7'd0);
    for (i = 0; i < groups.size(); i++) begin
      if (i == groups.size() - 1) send_octet({1'b0, groups[i]}, eoc);
      else send_octet({1'b1, groups[i]}, 1'b0);
    end
  endtask

  // content that stops with more groups announced
  task automatic send_cut_subid();
    int unsigned n;
    int unsigned i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) send_octet({1'b1, 7'($urandom_range(0, 127))}, i == n - 1);
  endtask

  function automatic logic [63:0] rand_arc();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 64'($urandom_range(0, 127));
      4, 5:       return 64'($urandom_range(128, 16383));
      6:          return 64'($urandom_range(0, 2097151));
      7:          return 64'($urandom);
      8:          return 64'h0000_0000_ffff_ffff - 64'($urandom_range(0, 3));
      default:    return {32'($urandom), 32'($urandom)} >> $urandom_range(0, 31);
    endcase
  endfunction

  // one well-formed identifier, sometimes cut short
  task automatic send_identifier();
    int unsigned n_sub;
    int unsigned k;
    int unsigned pad;
    bit          cut;
    logic [63:0] value;
    n_sub = $urandom_range(1, 6);
    cut   = ($urandom_range(0, 19) == 0);
    for (k = 0; k < n_sub; k++) begin
      if (k == 0 && $urandom_range(0, 3) != 0) value = 64'($urandom_range(0, 160));
      else value = rand_arc();
      pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
      send_subid(value, pad, !cut && k == n_sub - 1);
    end
    if (cut) send_cut_subid();
  endtask

  // mostly identifiers, some raw octet noise
  task automatic random_step();
    if ($urandom_range(0, 9) == 0)
      send_octet(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0));
    else
      send_identifier();
  endtask

  initial begin : stimulus
    rst                   <= 1'b1;
    hold_request          <= 1'b0;
    octets.valid          <= 1'b0;
    octets.content_byte   <= 8'h00;
    octets.end_of_content <= 1'b0;
    steady      = 1'b0;
    burst_left  = 0;
    octets_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: split points, widest arc, padding, overflow, truncation
    send_subid(64'd0, 0, 1'b1);
    send_subid(64'd39, 0, 1'b0);
    send_subid(64'd40, 0, 1'b1);
    send_subid(64'd79, 0, 1'b0);
    send_subid(64'hffff_ffff, 0, 1'b1);
    send_subid(64'd80, 1, 1'b1);
    send_subid(64'h1_0000_0000, 0, 1'b1);
    send_octet(8'h85, 1'b1);
    send_subid(64'd127, 0, 1'b0);
    repeat (4) send_octet(8'hff, 1'b0);
    send_octet(8'hff, 1'b1);

    while (octets_sent < HOLD_AFTER) random_step();

    // let the decoder drain completely
    octets.valid <= 1'b0;
    do @(posedge clk); while (arcs_pending != 0);

    // long output hold while octets keep coming
    hold_request <= 1'b1;
    steady = 1'b1;
    repeat (10) send_identifier();
    steady = 1'b0;
    hold_request <= 1'b0;

    while (octets_sent < ITEM_TARGET) random_step();

    octets.valid <= 1'b0;
    do @(posedge clk); while (arcs_pending != 0);
    repeat (10) @(posedge clk);

    if (fail_count == 0)
      $display("oid_subidentifier_decoder_unit_test passed");
    else
      $display("oid_subidentifier_decoder_unit_test failed");
    $finish;
  end

endmodule
